// ===== sv/cf4_pkg.sv =====
`default_nettype none

package cf4_pkg;

    // command codes carried in the input tuser
    localparam logic [1:0] CMD_LOAD_SEG   = 2'd0;
    localparam logic [1:0] CMD_LOAD_GLYPH = 2'd1;
    localparam logic [1:0] CMD_LOOKUP     = 2'd2;

    // field widths fixed by the table format
    localparam int CODE_W     = 16;
    localparam int IDX_W      = 12;
    localparam int CMD_W      = 2;
    localparam int SEG_WORD_W = 4 * CODE_W;
    localparam int S_TDATA_W  = 112;
    localparam int CFG_W      = 9;

    // input tdata field offsets, lowest first
    localparam int OFS_INDEX = 0;
    localparam int OFS_END   = OFS_INDEX + IDX_W;
    localparam int OFS_START = OFS_END + CODE_W;
    localparam int OFS_DELTA = OFS_START + CODE_W;
    localparam int OFS_RO    = OFS_DELTA + CODE_W;
    localparam int OFS_GWORD = OFS_RO + CODE_W;
    localparam int OFS_CODE  = OFS_GWORD + CODE_W;

    // signed width of the glyph array address sum
    localparam int ADDR_SUM_W = 19;

    // lookup sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_CHECK = 6'b000100,
        S_ADDR  = 6'b001000,
        S_GREAD = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

endpackage : cf4_pkg

`default_nettype wire

// ===== sv/cf4_ram.sv =====
`default_nettype none

module cf4_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule : cf4_ram

`default_nettype wire

// ===== sv/cf4_seq.sv =====
`default_nettype none

module cf4_seq
    import cf4_pkg::*;
#(
    parameter  int MAX_SEGMENTS = 256,
    parameter  int GLYPH_WORDS  = 4096,
    localparam int SEG_AW       = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
    localparam int GW_AW        = (GLYPH_WORDS > 1) ? $clog2(GLYPH_WORDS) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [CODE_W-1:0]     i_code,
    input  wire logic [CFG_W-1:0]      i_seg_count,
    output logic                       o_idle,
    output logic      [SEG_AW-1:0]     o_seg_raddr,
    input  wire logic [SEG_WORD_W-1:0] i_seg_rdata,
    output logic      [GW_AW-1:0]      o_glyph_raddr,
    input  wire logic [CODE_W-1:0]     i_glyph_rdata,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic      [CODE_W-1:0]     o_m_glyph,
    output logic                       o_m_miss
);

    localparam int CNT_W = SEG_AW + 1;
    localparam int EXT_W = 17;

    t_state r_state, n_state;
    logic [SEG_AW-1:0]     r_seg, n_seg;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CODE_W-1:0]     r_code, n_code;
    logic [CODE_W-1:0]     r_start, n_start;
    logic [CODE_W-1:0]     r_delta, n_delta;
    logic [CODE_W-1:0]     r_ro, n_ro;
    logic [CODE_W:0]       r_acc, n_acc;
    logic [CODE_W-1:0]     r_res_glyph, n_res_glyph;
    logic                  r_res_miss, n_res_miss;
    logic                  r_out_valid, n_out_valid;
    logic [CODE_W-1:0]     r_out_glyph, n_out_glyph;
    logic                  r_out_miss, n_out_miss;

    logic [EXT_W-1:0]      cnt_ext;
    logic [EXT_W-1:0]      cnt_eff;
    logic [CNT_W-1:0]      seg_next;
    logic [CODE_W-1:0]     seg_end;
    logic [ADDR_SUM_W-1:0] addr_sum;
    logic                  addr_ok;

    // segment count clamped to the table depth
    assign cnt_ext = {{(EXT_W - CFG_W){1'b0}}, i_seg_count};
    assign cnt_eff = (cnt_ext > EXT_W'(MAX_SEGMENTS)) ? EXT_W'(MAX_SEGMENTS) : cnt_ext;

    assign seg_next = CNT_W'(r_seg) + CNT_W'(1);
    assign seg_end  = i_seg_rdata[CODE_W-1:0];

    // glyph array address: offset part plus segment index minus count
    assign addr_sum = {{(ADDR_SUM_W - CODE_W - 1){1'b0}}, r_acc}
                    + ADDR_SUM_W'(r_seg) - ADDR_SUM_W'(r_count);
    assign addr_ok  = !addr_sum[ADDR_SUM_W-1]
                    && (addr_sum < ADDR_SUM_W'(GLYPH_WORDS));

    // next state and datapath
    always_comb begin
        n_state     = r_state;
        n_seg       = r_seg;
        n_count     = r_count;
        n_code      = r_code;
        n_start     = r_start;
        n_delta     = r_delta;
        n_ro        = r_ro;
        n_acc       = r_acc;
        n_res_glyph = r_res_glyph;
        n_res_miss  = r_res_miss;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_glyph = r_out_glyph;
        n_out_miss  = r_out_miss;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_code  = i_code;
                    n_count = cnt_eff[CNT_W-1:0];
                    n_seg   = '0;
                    if (cnt_eff == '0) begin
                        n_res_glyph = '0;
                        n_res_miss  = 1'b1;
                        n_state     = S_OUT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            // one segment end compared per cycle
            S_SCAN: begin
                if (seg_end >= r_code) begin
                    n_start = i_seg_rdata[2*CODE_W-1:CODE_W];
                    n_delta = i_seg_rdata[3*CODE_W-1:2*CODE_W];
                    n_ro    = i_seg_rdata[4*CODE_W-1:3*CODE_W];
                    n_state = S_CHECK;
                end else if (seg_next >= r_count) begin
                    n_res_glyph = '0;
                    n_res_miss  = 1'b1;
                    n_state     = S_OUT;
                end else begin
                    n_seg = seg_next[SEG_AW-1:0];
                end
            end
            S_CHECK: begin
                if (r_code < r_start) begin
                    n_res_glyph = '0;
                    n_res_miss  = 1'b1;
                    n_state     = S_OUT;
                end else if (r_ro == '0) begin
                    n_res_glyph = r_delta + r_code;
                    n_res_miss  = 1'b0;
                    n_state     = S_OUT;
                end else begin
                    n_acc   = {1'b0, r_code - r_start} + {2'b00, r_ro[CODE_W-1:1]};
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                if (addr_ok) begin
                    n_state = S_GREAD;
                end else begin
                    n_res_glyph = '0;
                    n_res_miss  = 1'b1;
                    n_state     = S_OUT;
                end
            end
            // zero word stays zero, otherwise delta is added
            S_GREAD: begin
                n_res_glyph = (i_glyph_rdata != '0) ? (i_glyph_rdata + r_delta) : '0;
                n_res_miss  = 1'b0;
                n_state     = S_OUT;
            end
            // wait for the output register to free up
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_glyph = r_res_glyph;
                    n_out_miss  = r_res_miss;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_seg       <= n_seg;
        r_count     <= n_count;
        r_code      <= n_code;
        r_start     <= n_start;
        r_delta     <= n_delta;
        r_ro        <= n_ro;
        r_acc       <= n_acc;
        r_res_glyph <= n_res_glyph;
        r_res_miss  <= n_res_miss;
        r_out_glyph <= n_out_glyph;
        r_out_miss  <= n_out_miss;
    end

    // segment read follows the next index so data lines up with r_seg
    assign o_seg_raddr   = n_seg;
    assign o_glyph_raddr = addr_sum[GW_AW-1:0];
    assign o_idle        = (r_state == S_IDLE);
    assign o_m_tvalid    = r_out_valid;
    assign o_m_glyph     = r_out_glyph;
    assign o_m_miss      = r_out_miss;

endmodule : cf4_seq

`default_nettype wire

// ===== sv/cmap_format4_glyph_lookup.sv =====
// channel   | direction | word contents (low bit first)
// ----------+-----------+-----------------------------------------------------------
// s_axis    | in        | tdata: index, last_code, first_code, delta, range_offset,
//           |           |        glyph_word, code_point; tuser: command
// m_axis    | out       | tdata: glyph; tuser: miss
// cfg       | in        | data: segment_count
//
// loads are written as they are accepted. a lookup scans the segments one by one, at most
// the segment count of them: the segment table has one read port and the end codes
// are compared one per cycle; then the start is checked, and the glyph array address and
// read follow where the range offset is nonzero. the input is not ready while a lookup
// runs; a finished result waits in the output register, and a lookup holds there if
// the previous result is still not taken.
// synchronous reset sets the segment count to 1; the tables are not cleared.
`default_nettype none

module cmap_format4_glyph_lookup
    import cf4_pkg::*;
#(
    parameter int MAX_SEGMENTS = 256,
    parameter int GLYPH_WORDS  = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // index, last_code, first_code, delta, range_offset, glyph_word, code_point
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // command
    input  wire logic [CMD_W-1:0]     i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // glyph
    output logic      [CODE_W-1:0]    o_m_axis_tdata,
    // miss
    output logic      [0:0]           o_m_axis_tuser,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int GW_AW  = (GLYPH_WORDS > 1) ? $clog2(GLYPH_WORDS) : 1;
    localparam int EXT_W  = 17;

    logic [CFG_W-1:0]      r_seg_count;
    logic                  accept;
    logic [CMD_W-1:0]      cmd;
    logic [EXT_W-1:0]      idx_ext;
    logic                  seg_we;
    logic                  glyph_we;
    logic                  start;
    logic                  idle;
    logic [SEG_WORD_W-1:0] seg_wdata;
    logic [SEG_AW-1:0]     seg_raddr;
    logic [SEG_WORD_W-1:0] seg_rdata;
    logic [GW_AW-1:0]      glyph_raddr;
    logic [CODE_W-1:0]     glyph_rdata;
    logic                  out_miss;

    // segment count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            r_seg_count <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // command decode on an accepted word
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign cmd     = i_s_axis_tuser;
    assign idx_ext = {{(EXT_W - IDX_W){1'b0}}, i_s_axis_tdata[OFS_INDEX +: IDX_W]};
    assign seg_we  = accept && (cmd == CMD_LOAD_SEG)
                   && (idx_ext < EXT_W'(MAX_SEGMENTS));
    assign glyph_we = accept && (cmd == CMD_LOAD_GLYPH)
                    && (idx_ext < EXT_W'(GLYPH_WORDS));
    assign start   = accept && (cmd == CMD_LOOKUP);

    // segment entry: end, start, delta, range offset from the low bits up
    assign seg_wdata = {i_s_axis_tdata[OFS_RO +: CODE_W],
                        i_s_axis_tdata[OFS_DELTA +: CODE_W],
                        i_s_axis_tdata[OFS_START +: CODE_W],
                        i_s_axis_tdata[OFS_END +: CODE_W]};

    cf4_ram #(
        .WIDTH (SEG_WORD_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (seg_we),
        .i_waddr (idx_ext[SEG_AW-1:0]),
        .i_wdata (seg_wdata),
        .i_raddr (seg_raddr),
        .o_rdata (seg_rdata)
    );

    cf4_ram #(
        .WIDTH (CODE_W),
        .DEPTH (GLYPH_WORDS)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (glyph_we),
        .i_waddr (idx_ext[GW_AW-1:0]),
        .i_wdata (i_s_axis_tdata[OFS_GWORD +: CODE_W]),
        .i_raddr (glyph_raddr),
        .o_rdata (glyph_rdata)
    );

    cf4_seq #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .GLYPH_WORDS  (GLYPH_WORDS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_code        (i_s_axis_tdata[OFS_CODE +: CODE_W]),
        .i_seg_count   (r_seg_count),
        .o_idle        (idle),
        .o_seg_raddr   (seg_raddr),
        .i_seg_rdata   (seg_rdata),
        .o_glyph_raddr (glyph_raddr),
        .i_glyph_rdata (glyph_rdata),
        .o_m_tvalid    (o_m_axis_tvalid),
        .i_m_tready    (i_m_axis_tready),
        .o_m_glyph     (o_m_axis_tdata),
        .o_m_miss      (out_miss)
    );

    assign o_s_axis_tready = idle;
    assign o_m_axis_tuser  = out_miss;

endmodule : cmap_format4_glyph_lookup

`default_nettype wire
